### design/sid_pkg.sv
// ----------------------------------------------------------------------------
// sid_pkg: shared types and constants of the signed integer divider
// Operand width and the word that moves from cell to cell along the array.
// ----------------------------------------------------------------------------
package sid_pkg;

  localparam int unsigned WIDTH = 32;

  // One division in flight: partial remainder, dividend bits still to come
  // with quotient bits shifted in behind them, divisor magnitude and flags.
  typedef struct packed {
    logic [WIDTH-1:0] rem;
    logic [WIDTH-1:0] nq;
    logic [WIDTH-1:0] den;
    logic             q_neg;
    logic             den_zero;
  } stage_t;

endpackage

### design/sid_cell.sv
// ----------------------------------------------------------------------------
// sid_cell: one restoring division step
// Shifts in the next dividend bit, trial-subtracts the divisor, records the
// quotient bit and registers the word for the next cell.
// ----------------------------------------------------------------------------
module sid_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  sid_pkg::stage_t data_i,
  output logic            ready_o,
  output logic            valid_o,
  output sid_pkg::stage_t data_o,
  input  logic            ready_i
);
  import sid_pkg::*;

  logic             valid_q;
  stage_t           data_q;
  stage_t           data_d;
  logic [WIDTH-1:0] rem_sh;
  logic [WIDTH:0]   diff;

  // Remainder stays below the divisor, so its top bit is always clear.
  assign rem_sh = {data_i.rem[WIDTH-2:0], data_i.nq[WIDTH-1]};
  assign diff   = {1'b0, rem_sh} - {1'b0, data_i.den};

  always_comb begin
    data_d = data_i;
    if (!diff[WIDTH]) begin
      data_d.rem = diff[WIDTH-1:0];
      data_d.nq  = {data_i.nq[WIDTH-2:0], 1'b1};
    end else begin
      data_d.rem = rem_sh;
      data_d.nq  = {data_i.nq[WIDTH-2:0], 1'b0};
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

### design/signed_integer_divider.sv
// Throughput: one word per cycle while the output is not held back; each of the
// WIDTH division cells holds one word and passes it on, so up to WIDTH+2
// divisions are in flight at once.
// Reset: rst_ni low clears every stage valid flag asynchronously; data held in
// the stages is not reset.
// ----------------------------------------------------------------------------
// signed_integer_divider: pipelined signed divider, truncating toward zero
// Sign/magnitude stage, a row of restoring cells, then sign fix-up with zero
// for a zero divisor and for the overflowing most-negative over minus one.
// ----------------------------------------------------------------------------
module signed_integer_divider (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [sid_pkg::WIDTH-1:0] numerator_i,
  input  logic signed [sid_pkg::WIDTH-1:0] denominator_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [sid_pkg::WIDTH-1:0] quotient_o
);
  import sid_pkg::*;

  // Prep stage
  logic             prep_v_q;
  stage_t           prep_q;
  stage_t           prep_d;
  logic             n_neg;
  logic             d_neg;

  // Cell chain: index k is the input side of cell k, index WIDTH the far end
  logic             chain_v   [WIDTH+1];
  stage_t           chain_d   [WIDTH+1];
  logic             chain_rdy [WIDTH+1];

  // Output stage
  logic             out_v_q;
  logic [WIDTH-1:0] quo_q;
  logic [WIDTH-1:0] quo_d;
  stage_t           last;

  assign n_neg = numerator_i[WIDTH-1];
  assign d_neg = denominator_i[WIDTH-1];

  // Negating the most negative value yields its own bit pattern, which is
  // the correct unsigned magnitude.
  always_comb begin
    prep_d.rem      = '0;
    prep_d.nq       = n_neg ? (~numerator_i + 1'b1) : numerator_i;
    prep_d.den      = d_neg ? (~denominator_i + 1'b1) : denominator_i;
    prep_d.q_neg    = n_neg ^ d_neg;
    prep_d.den_zero = (denominator_i == '0);
  end

  assign in_ready_o = !prep_v_q || chain_rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_v_q <= 1'b0;
    end else if (in_ready_o) begin
      prep_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      prep_q <= prep_d;
    end
  end

  assign chain_v[0] = prep_v_q;
  assign chain_d[0] = prep_q;

  for (genvar k = 0; k < WIDTH; k++) begin : g_cell
    sid_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_v[k]),
      .data_i  (chain_d[k]),
      .ready_o (chain_rdy[k]),
      .valid_o (chain_v[k+1]),
      .data_o  (chain_d[k+1]),
      .ready_i (chain_rdy[k+1])
    );
  end

  assign last           = chain_d[WIDTH];
  assign chain_rdy[WIDTH] = !out_v_q || out_ready_i;

  // nq now holds the quotient magnitude
  always_comb begin
    if (last.den_zero) begin
      quo_d = '0;
    end else if (!last.q_neg && last.nq[WIDTH-1]) begin
      quo_d = '0;
    end else if (last.q_neg) begin
      quo_d = ~last.nq + 1'b1;
    end else begin
      quo_d = last.nq;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (chain_rdy[WIDTH]) begin
      out_v_q <= chain_v[WIDTH];
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain_rdy[WIDTH] && chain_v[WIDTH]) begin
      quo_q <= quo_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign quotient_o  = quo_q;

`ifndef SYNTH
  // Input side only stalls when every stage is full behind a held result.
  a_stall_only_on_backpressure : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && chain_v[WIDTH] && prep_v_q))
    else $error("input stalled without output backpressure");

  // A result appears only when the last cell handed one over.
  a_result_from_chain : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(chain_v[WIDTH]))
    else $error("result word appeared without a word from the cell row");

  // A divisor magnitude with its top bit set can only be the most negative value.
  a_den_mag_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (prep_v_q && prep_q.den[WIDTH-1]) |-> (prep_q.den[WIDTH-2:0] == '0))
    else $error("divisor magnitude out of range");
`endif

endmodule
